@@ rtl/stt_pkg.sv @@
`timescale 1ns / 1ps
package stt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_ESCAPE  = 3'd5
  } mode_t;

  localparam logic [5:0] KIND_NAME     = 6'd0;
  localparam logic [5:0] KIND_NUMBER   = 6'd1;
  localparam logic [5:0] KIND_KEYWORD0 = 6'd2;
  localparam logic [5:0] KIND_PUNCT0   = 6'd13;
  localparam logic [5:0] KIND_STRING   = 6'd32;
  localparam logic [5:0] KIND_UNKNOWN  = 6'd33;
  localparam logic [5:0] KIND_END      = 6'd34;
  localparam logic [5:0] KIND_CHAR     = 6'd35;

  localparam int NUM_KW   = 11;
  localparam int KW_BYTES = 8;
  localparam int NUM_PUNCT = 19;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [15:0] length;
    logic [7:0]  char_value;
    logic        last;
  } token_t;

  // front-to-back word: up to two tokens from one byte
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } pair_t;

  function automatic logic [63:0] kw_text(input int k);
    case (k)
      0:  kw_text = {48'd0, "nf"};
      1:  kw_text = {16'd0, "nruter"};
      2:  kw_text = {24'd0, "elihw"};
      3:  kw_text = {40'd0, "rof"};
      4:  kw_text = "eunitnoc";
      5:  kw_text = {24'd0, "kaerb"};
      6:  kw_text = {48'd0, "fi"};
      7:  kw_text = {32'd0, "esle"};
      8:  kw_text = {32'd0, "eurt"};
      9:  kw_text = {24'd0, "eslaf"};
      default: kw_text = {32'd0, "diov"};
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      0, 6: kw_len = 4'd2;
      1: kw_len = 4'd6;
      2, 5, 9: kw_len = 4'd5;
      3: kw_len = 4'd3;
      4: kw_len = 4'd8;
      default: kw_len = 4'd4;
    endcase
  endfunction

  function automatic logic [7:0] punct_char(input int i);
    case (i)
      0: punct_char = "{";  1: punct_char = "}";  2: punct_char = "(";
      3: punct_char = ")";  4: punct_char = "[";  5: punct_char = "]";
      6: punct_char = ";";  7: punct_char = ":";  8: punct_char = ",";
      9: punct_char = ".";  10: punct_char = "="; 11: punct_char = "+";
      12: punct_char = "-"; 13: punct_char = "/"; 14: punct_char = "%";
      15: punct_char = "*"; 16: punct_char = "<"; 17: punct_char = ">";
      default: punct_char = "!";
    endcase
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

@@ rtl/stt_front.sv @@
`timescale 1ns / 1ps
module stt_front #(
  parameter int KEYWORD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output logic              q_valid,
  input  logic              q_ready,
  output stt_pkg::pair_t    q_data
);

  localparam int LW = $clog2(KEYWORD_BYTES);

  stt_pkg::mode_t mode, mode_next;
  logic [7:0]  wbuf [KEYWORD_BYTES];
  logic [15:0] run_len, run_len_next;
  logic [15:0] cur_row, cur_col, beg_row, beg_col;
  logic [15:0] beg_row_next, beg_col_next;
  logic        start_row, untouched;
  logic        take;
  logic        b_space, b_alpha, b_digit, b_nl;
  logic        clr_buf, wr_buf;
  logic [LW-1:0] wr_idx;
  logic [5:0]  name_k, punct_k;
  logic        punct_hit;
  stt_pkg::token_t t_flush, t_start, t_char, t_end, t0, t1;
  logic        v0, v1, f_en, s_en, c_en, e_en;
  logic [7:0]  esc_ch;

  assign take     = in_valid && in_ready;
  assign in_ready = !q_valid || q_ready;

  assign b_space = (in_byte == 8'd32) || (in_byte >= 8'd9 && in_byte <= 8'd13);
  assign b_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
  assign b_digit = in_byte >= "0" && in_byte <= "9";
  assign b_nl    = in_byte == 8'd10;

  always_comb begin
    name_k = stt_pkg::KIND_NAME;
    for (int k = stt_pkg::NUM_KW - 1; k >= 0; k--) begin
      logic same;
      logic [63:0] kw;
      kw = stt_pkg::kw_text(k);
      same = (run_len == {12'd0, stt_pkg::kw_len(k)});
      for (int i = 0; i < stt_pkg::KW_BYTES; i++) begin
        if (i < int'(stt_pkg::kw_len(k)) && wbuf[i] != kw[i*8 +: 8])
          same = 1'b0;
      end
      if (same) name_k = stt_pkg::KIND_KEYWORD0 + 6'(k);
    end
  end

  always_comb begin
    punct_hit = 1'b0;
    punct_k   = stt_pkg::KIND_UNKNOWN;
    for (int i = stt_pkg::NUM_PUNCT - 1; i >= 0; i--) begin
      if (in_byte == stt_pkg::punct_char(i)) begin
        punct_hit = 1'b1;
        punct_k   = stt_pkg::KIND_PUNCT0 + 6'(i);
      end
    end
  end

  always_comb begin
    case (in_byte)
      "n":     esc_ch = 8'd10;
      "\\":    esc_ch = 8'd92;
      "t":     esc_ch = 8'd9;
      "\"":    esc_ch = 8'd34;
      default: esc_ch = 8'd0;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    run_len_next = run_len;
    beg_row_next = beg_row;
    beg_col_next = beg_col;
    clr_buf = 1'b0;
    wr_buf  = 1'b0;
    wr_idx  = run_len[LW-1:0];
    f_en = 1'b0; s_en = 1'b0; c_en = 1'b0; e_en = 1'b0;
    t_flush = '0;
    t_flush.row = beg_row;
    t_flush.column = beg_col;
    t_flush.length = run_len;
    t_start = '0;
    t_start.row = cur_row;
    t_start.column = cur_col;
    t_start.length = 16'd1;
    t_start.kind = punct_k;
    t_char = t_start;
    t_char.kind = stt_pkg::KIND_CHAR;
    t_char.char_value = in_byte;
    t_end = '0;
    t_end.kind = stt_pkg::KIND_END;
    t_end.row = cur_row;
    t_end.column = cur_col;
    case (mode)
      stt_pkg::MODE_NAME:   t_flush.kind = name_k;
      stt_pkg::MODE_NUMBER: t_flush.kind = stt_pkg::KIND_NUMBER;
      default:              t_flush.kind = stt_pkg::KIND_STRING;
    endcase
    if (in_end) begin
      f_en = (mode != stt_pkg::MODE_IDLE) && (mode != stt_pkg::MODE_COMMENT);
      e_en = 1'b1;
      mode_next = stt_pkg::MODE_IDLE;
      clr_buf = 1'b1;
      run_len_next = '0;
      beg_row_next = '0;
      beg_col_next = '0;
    end else begin
      logic do_start;
      do_start = 1'b0;
      case (mode)
        stt_pkg::MODE_NAME: begin
          if (b_alpha || b_digit) begin
            wr_buf = run_len < 16'(KEYWORD_BYTES);
            run_len_next = stt_pkg::sat_inc(run_len);
          end else begin
            f_en = 1'b1;
            do_start = 1'b1;
          end
        end
        stt_pkg::MODE_NUMBER: begin
          if (b_digit) run_len_next = stt_pkg::sat_inc(run_len);
          else begin
            f_en = 1'b1;
            do_start = 1'b1;
          end
        end
        stt_pkg::MODE_COMMENT: if (b_nl) mode_next = stt_pkg::MODE_IDLE;
        stt_pkg::MODE_STRING: begin
          if (in_byte == "\"") begin
            f_en = 1'b1;
            mode_next = stt_pkg::MODE_IDLE;
          end else if (in_byte == "\\") mode_next = stt_pkg::MODE_ESCAPE;
          else begin
            c_en = 1'b1;
            run_len_next = stt_pkg::sat_inc(run_len);
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          c_en = 1'b1;
          t_char.length = 16'd2;
          t_char.char_value = esc_ch;
          run_len_next = stt_pkg::sat_inc(run_len);
          mode_next = stt_pkg::MODE_STRING;
        end
        default: do_start = 1'b1;
      endcase
      if (do_start) begin
        mode_next = stt_pkg::MODE_IDLE;
        beg_row_next = cur_row;
        beg_col_next = cur_col;
        if (b_space) begin
        end else if (in_byte == "#") mode_next = stt_pkg::MODE_COMMENT;
        else if (b_alpha) begin
          mode_next = stt_pkg::MODE_NAME;
          clr_buf = 1'b1;
          wr_buf = 1'b1;
          wr_idx = '0;
          run_len_next = 16'd1;
        end else if (b_digit) begin
          mode_next = stt_pkg::MODE_NUMBER;
          run_len_next = 16'd1;
        end else if (in_byte == "\"") begin
          mode_next = stt_pkg::MODE_STRING;
          run_len_next = '0;
        end else s_en = 1'b1;
      end
    end
    v0 = f_en || s_en || c_en || e_en;
    v1 = f_en && (s_en || e_en);
    t0 = f_en ? t_flush : (c_en ? t_char : (e_en ? t_end : t_start));
    t1 = e_en ? t_end : t_start;
    t0.last = !v1;
    t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= stt_pkg::MODE_IDLE;
      run_len   <= '0;
      cur_row   <= 16'd1;
      cur_col   <= 16'd1;
      beg_row   <= '0;
      beg_col   <= '0;
      start_row <= 1'b1;
      untouched <= 1'b1;
      q_valid   <= 1'b0;
      for (int i = 0; i < KEYWORD_BYTES; i++) wbuf[i] <= '0;
    end else begin
      if (take) q_valid <= v0;
      else if (q_ready) q_valid <= 1'b0;
      if (cfg_we) begin
        start_row <= cfg_data;
        if (untouched) cur_row <= {15'd0, cfg_data};
      end
      if (take) begin
        mode    <= mode_next;
        run_len <= run_len_next;
        beg_row <= beg_row_next;
        beg_col <= beg_col_next;
        for (int i = 0; i < KEYWORD_BYTES; i++) begin
          if (wr_buf && wr_idx == LW'(i)) wbuf[i] <= in_byte;
          else if (clr_buf) wbuf[i] <= '0;
        end
        if (in_end) begin
          cur_row   <= {15'd0, start_row};
          cur_col   <= 16'd1;
          untouched <= 1'b1;
        end else begin
          untouched <= 1'b0;
          if (b_nl) begin
            cur_row <= stt_pkg::sat_inc(cur_row);
            cur_col <= 16'd1;
          end else cur_col <= stt_pkg::sat_inc(cur_col);
        end
        if (v0) begin
          q_data.two    <= v1;
          q_data.first  <= t0;
          q_data.second <= t1;
        end
      end
    end
  end

endmodule

@@ rtl/stt_back.sv @@
`timescale 1ns / 1ps
module stt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  stt_pkg::pair_t    q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::token_t   out_token
);

  // two-entry queue of pairs, then serialize
  stt_pkg::pair_t mem [2];
  logic       wp, rp, sel;
  logic [1:0] cnt;
  logic       pop, push;

  assign q_ready   = cnt != 2'd2;
  assign push      = q_valid && q_ready;
  assign out_valid = cnt != 2'd0;
  assign out_token = sel ? mem[rp].second : mem[rp].first;
  assign pop       = out_valid && out_ready && (sel || !mem[rp].two);

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; sel <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) begin
        rp <= !rp;
        sel <= 1'b0;
      end else if (out_valid && out_ready) sel <= 1'b1;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// Source text tokenizer.
// s_axis takes one text byte per word (tdata) with tuser = end of text.
// m_axis gives one token per word; tuser carries the token kind and tlast
// marks the final token caused by a byte.
// cfg_we/cfg_data write the start row (1 bit) used for the first line.
// The front stage classifies one byte per cycle while the queue takes its output
// and registers up to two tokens; a two-entry queue feeds the back stage, which
// hands tokens out one per cycle while m_axis_tready is high. Throughput is one
// byte per cycle while each byte yields at most one token; a byte that closes a
// name or number and is itself a one-byte token yields two tokens in turn.
// Reset (rst, synchronous) returns to idle, row 1, column 1, and sets the start row to 1.
// When m_axis stalls the queue fills and s_axis_tready drops; no data is lost.
// After end of text the tokenizer restarts at the start row, column 1.
module source_text_tokenizer #(
  parameter int KEYWORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tuser,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // row[15:0] column[31:16] length[47:32] char[55:48]
  output logic [5:0]  m_axis_tuser,   // kind[5:0]
  output logic        m_axis_tlast    // last_result
);

  stt_pkg::pair_t  q_data;
  stt_pkg::token_t tok;
  logic q_valid, q_ready;

  stt_front #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_front (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_end(s_axis_tuser),
    .q_valid, .q_ready, .q_data
  );

  stt_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_token(tok)
  );

  assign m_axis_tdata = {tok.char_value, tok.length, tok.column, tok.row};
  assign m_axis_tuser = tok.kind;
  assign m_axis_tlast = tok.last;

endmodule

@@ tb/source_text_tokenizer_test.sv @@
`timescale 1ns / 1ps
module source_text_tokenizer_test;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_data = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        m_axis_tlast;

  source_text_tokenizer dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

  text_word_t        text_q[$];
  stt_pkg::token_t   token_q[$];
  stt_pkg::token_t   step_tokens[$];
  int         errors = 0;
  bit         quiet = 0;
  int         hold_asks = 0;
  int         hold_seen = 0;

  // tokenizer shadow state
  string      kw_names[11] = '{"fn", "return", "while", "for", "continue", "break",
                               "if", "else", "true", "false", "void"};
  string      punct_set = "{}()[];:,.=+-/%*<>!";
  logic       row_cfg = 1;
  stt_pkg::mode_t lex = stt_pkg::MODE_IDLE;
  logic [7:0] name_buf[8] = '{default: 8'd0};
  logic [15:0] run_len = 0;
  logic [15:0] cur_row = 1;
  logic [15:0] cur_col = 1;
  logic [15:0] beg_row = 0;
  logic [15:0] beg_col = 0;
  bit          untouched = 1;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic add_token(logic [5:0] kind, logic [15:0] row, logic [15:0] col,
                           logic [15:0] len, logic [7:0] cv);
    stt_pkg::token_t t;
    t.kind = kind; t.row = row; t.column = col; t.length = len;
    t.char_value = cv; t.last = 0;
    if (step_tokens.size() < 2) step_tokens.push_back(t);
  endtask

  function automatic logic [5:0] name_kind();
    bit same;
    for (int k = 0; k < 11; k++) begin
      if (run_len != kw_names[k].len()) continue;
      same = 1;
      for (int i = 0; i < kw_names[k].len(); i++)
        if (name_buf[i] != kw_names[k][i]) same = 0;
      if (same) return stt_pkg::KIND_KEYWORD0 + 6'(k);
    end
    return stt_pkg::KIND_NAME;
  endfunction

  task automatic flush_word();
    case (lex)
      stt_pkg::MODE_NAME: add_token(name_kind(), beg_row, beg_col, run_len, 0);
      stt_pkg::MODE_NUMBER: add_token(stt_pkg::KIND_NUMBER, beg_row, beg_col, run_len, 0);
      stt_pkg::MODE_STRING, stt_pkg::MODE_ESCAPE:
        add_token(stt_pkg::KIND_STRING, beg_row, beg_col, run_len, 0);
      default: ;
    endcase
    lex = stt_pkg::MODE_IDLE;
  endtask

  task automatic open_token(logic [7:0] b);
    beg_row = cur_row;
    beg_col = cur_col;
    if (is_space(b)) return;
    if (b == "#") lex = stt_pkg::MODE_COMMENT;
    else if (is_alpha(b)) begin
      lex = stt_pkg::MODE_NAME;
      name_buf = '{default: 8'd0};
      name_buf[0] = b;
      run_len = 1;
    end else if (is_digit(b)) begin
      lex = stt_pkg::MODE_NUMBER;
      run_len = 1;
    end else if (b == "\"") begin
      lex = stt_pkg::MODE_STRING;
      run_len = 0;
    end else begin
      for (int i = 0; i < 19; i++)
        if (b == punct_set[i]) begin
          add_token(stt_pkg::KIND_PUNCT0 + 6'(i), cur_row, cur_col, 1, 0);
          return;
        end
      add_token(stt_pkg::KIND_UNKNOWN, cur_row, cur_col, 1, 0);
    end
  endtask

  task automatic lex_word(logic [7:0] b, logic eot);
    logic [7:0] dec;
    step_tokens.delete();
    if (eot) begin
      flush_word();
      add_token(stt_pkg::KIND_END, cur_row, cur_col, 0, 0);
      lex = stt_pkg::MODE_IDLE;
      name_buf = '{default: 8'd0};
      run_len = 0;
      cur_row = 16'(row_cfg);
      cur_col = 1;
      beg_row = 0;
      beg_col = 0;
      untouched = 1;
    end else begin
      untouched = 0;
      case (lex)
        stt_pkg::MODE_NAME:
          if (is_alpha(b) || is_digit(b)) begin
            if (run_len < 8) name_buf[run_len] = b;
            run_len = bump(run_len);
          end else begin
            flush_word();
            open_token(b);
          end
        stt_pkg::MODE_NUMBER:
          if (is_digit(b)) run_len = bump(run_len);
          else begin
            flush_word();
            open_token(b);
          end
        stt_pkg::MODE_COMMENT:
          if (b == 8'd10) lex = stt_pkg::MODE_IDLE;
        stt_pkg::MODE_STRING:
          if (b == "\"") flush_word();
          else if (b == "\\") lex = stt_pkg::MODE_ESCAPE;
          else begin
            add_token(stt_pkg::KIND_CHAR, cur_row, cur_col, 1, b);
            run_len = bump(run_len);
          end
        stt_pkg::MODE_ESCAPE: begin
          if (b == "n") dec = 8'd10;
          else if (b == "\\") dec = 8'd92;
          else if (b == "t") dec = 8'd9;
          else if (b == "\"") dec = 8'd34;
          else dec = 8'd0;
          add_token(stt_pkg::KIND_CHAR, cur_row, cur_col, 2, dec);
          run_len = bump(run_len);
          lex = stt_pkg::MODE_STRING;
        end
        default: begin
          lex = stt_pkg::MODE_IDLE;
          open_token(b);
        end
      endcase
      if (b == 8'd10) begin
        cur_row = bump(cur_row);
        cur_col = 1;
      end else cur_col = bump(cur_col);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
    foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender
  int  tx_gap = 0;
  bit  tx_done = 0;
  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !tx_done)) begin
      tx_done = 0;
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 0;
      end else if (text_q.size() > 0) begin
        text_word_t w;
        w = text_q.pop_front();
        s_axis_tdata <= w.ch;
        s_axis_tuser <= w.eot;
        s_axis_tvalid <= 1;
        tx_gap <= pick_gap();
      end else s_axis_tvalid <= 0;
    end
  end

  // receiver
  int rx_gap = 0;
  int rx_hold = 0;
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      rx_hold <= 400;
      m_axis_tready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      rx_gap <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      lex_word(s_axis_tdata, s_axis_tuser);
      tx_done = 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      stt_pkg::token_t want;
      stt_pkg::token_t got;
      got.kind = m_axis_tuser;
      got.row = m_axis_tdata[15:0];
      got.column = m_axis_tdata[31:16];
      got.length = m_axis_tdata[47:32];
      got.char_value = m_axis_tdata[55:48];
      got.last = m_axis_tlast;
      if (token_q.size() == 0) begin
        errors++;
        if (errors < 30) $display("%0t: expected no token, got %p", $time, got);
      end else begin
        want = token_q.pop_front();
        if (want != got) begin
          errors++;
          if (errors < 30) $display("%0t: expected %p, got %p", $time, want, got);
        end
      end
    end
  end

  task automatic put_byte(logic [7:0] b);
    text_word_t w;
    w.ch = b; w.eot = 0;
    text_q.push_back(w);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_eot();
    text_word_t w;
    w.ch = 8'($urandom_range(0, 255)); w.eot = 1;
    text_q.push_back(w);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return "a" + 8'(r);
    if (r < 52) return "A" + 8'(r - 26);
    return "0" + 8'(r - 52);
  endfunction

  task automatic put_piece();
    int r;
    int n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 15) put_text(kw_names[$urandom_range(0, 10)]);
    else if (r < 30) begin
      if ($urandom_range(0, 3) == 0) put_text(kw_names[$urandom_range(0, 10)]);
      else put_byte($urandom_range(0, 1) ? "a" + 8'($urandom_range(0, 25))
                                         : "A" + 8'($urandom_range(0, 25)));
      n = $urandom_range(0, 11);
      repeat (n) put_byte(rand_alnum());
    end else if (r < 42) begin
      n = $urandom_range(1, 6);
      repeat (n) put_byte("0" + 8'($urandom_range(0, 9)));
    end else if (r < 60) put_byte(punct_set[$urandom_range(0, 18)]);
    else if (r < 72) begin
      put_byte("\"");
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: begin
            put_byte("\\");
            case ($urandom_range(0, 4))
              0: put_byte("n");
              1: put_byte("\\");
              2: put_byte("t");
              3: put_byte("\"");
              default: put_byte(8'($urandom_range(0, 255)));
            endcase
          end
          1: put_byte(8'($urandom_range(0, 255)) & 8'hDB | 8'h01);
          default: put_byte(8'($urandom_range(32, 126)) == "\"" ? "x"
                            : 8'($urandom_range(32, 126)));
        endcase
      end
      if ($urandom_range(0, 9) != 0) put_byte("\"");
    end else if (r < 77) begin
      put_byte("#");
      n = $urandom_range(0, 6);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        put_byte(c == 8'd10 ? 8'd11 : c);
      end
      put_byte(8'd10);
    end else if (r < 95) begin
      case ($urandom_range(0, 5))
        0: put_byte(8'd9);
        1: put_byte(8'd10);
        2: put_byte(8'd11);
        3: put_byte(8'd12);
        4: put_byte(8'd13);
        default: put_byte(" ");
      endcase
    end else put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic set_start_row(logic v);
    @(negedge clk);
    cfg_data <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    row_cfg = v;
    if (untouched) cur_row = 16'(v);
  endtask

  task automatic drain();
    while (text_q.size() > 0 || s_axis_tvalid || token_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int budget;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    set_start_row(0);
    put_text("fn return while for continue break if else true false void\n");
    put_text("{}()[];:,.=+-/%*<>!");
    put_text("ab9( 12x continuex \"a\\n\\\\\\t\\\"\\q\n\" #note\n");
    put_byte(8'd0);
    put_byte(8'd255);
    put_text("\"open\\");
    put_eot();
    put_text("#tail");
    put_eot();
    drain();

    set_start_row(1);
    quiet = 1;
    put_text(" 1");
    put_text("\"xy");
    put_eot();
    put_text("7");
    drain();
    set_start_row(0);
    put_eot();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      quiet = (phase == 3);
      if (phase == 2) hold_asks++;
      budget = 140;
      while (budget > 0) begin
        int prior;
        prior = text_q.size();
        put_piece();
        if ($urandom_range(0, 2) == 0) put_byte(" ");
        budget -= text_q.size() - prior;
      end
      if (phase != 5) put_eot();
      drain();
      set_start_row(phase[0]);
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
